### rtl/feed_sequence_gap_tracker_unit_macros.svh
// assertion macros for the feed sequence gap tracker
`ifndef FEED_SEQUENCE_GAP_TRACKER_UNIT_MACROS_SVH
`define FEED_SEQUENCE_GAP_TRACKER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle, sampled on clk, off during rst
`define FSGT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold, sampled on clk, off during rst
`define FSGT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### rtl/fsgt_pkg.sv
// constants and codes shared by the feed sequence gap tracker
package fsgt_pkg;

  // default sizes
  localparam int NUM_PORTS_DEF      = 4;
  localparam int PENDING_WINDOW_DEF = 64;
  localparam int HEADER_BYTES_DEF   = 8;

  // longest datagram still taken as a heartbeat
  localparam logic [15:0] HEARTBEAT_MAX_LEN = 16'd20;

  // packet classes
  localparam logic [2:0] CLS_HEARTBEAT   = 3'd0;
  localparam logic [2:0] CLS_ADMIN       = 3'd1;
  localparam logic [2:0] CLS_UNSEQUENCED = 3'd2;
  localparam logic [2:0] CLS_DATA        = 3'd3;
  localparam logic [2:0] CLS_IGNORED     = 3'd4;

  // order status codes
  localparam logic [2:0] ORD_NONE      = 3'd0;
  localparam logic [2:0] ORD_FIRST     = 3'd1;
  localparam logic [2:0] ORD_IN_ORDER  = 3'd2;
  localparam logic [2:0] ORD_DUPLICATE = 3'd3;
  localparam logic [2:0] ORD_EARLY     = 3'd4;

  // statistics counter slots
  localparam int STAT_TOTAL     = 0;
  localparam int STAT_HEARTBEAT = 1;
  localparam int STAT_ADMIN     = 2;
  localparam int STAT_UNSEQ     = 3;
  localparam int STAT_IN_ORDER  = 4;
  localparam int STAT_DUPLICATE = 5;
  localparam int STAT_EARLY     = 6;
  localparam int STAT_GAP       = 7;
  localparam int NUM_STATS      = 8;

endpackage

### rtl/feed_sequence_gap_tracker_unit.sv
// feed sequence gap tracker: header classing, per-stream tracker and statistics
//
// A request is taken when start is high and busy is low; one result follows for
// every request, shown for exactly one cycle with done high, done registered after
// the second stage. The first stage works on the stream's tracker entry read from
// the tracker memory at the accepting edge and works out the in-order shift or the
// early marks, the second drains consecutive pending marks and writes the entry
// back. A new request can be taken while the last one is in the second stage, and
// one taken on the write-back edge gets the written entry forwarded when it hits
// the same stream. The receiver cannot hold results off. After reset the tracker
// memory is swept to zero, one entry per cycle, over all NUM_PORTS*256 entries
// (1024 by default) with busy high.
`include "feed_sequence_gap_tracker_unit_macros.svh"

module feed_sequence_gap_tracker_unit
  import fsgt_pkg::*;
#(
  parameter int NUM_PORTS      = NUM_PORTS_DEF,
  parameter int PENDING_WINDOW = PENDING_WINDOW_DEF,
  parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [1:0]  port_index,
  input  logic [7:0]  unit_id,
  input  logic [31:0] seq_number,
  input  logic [7:0]  msg_count,
  input  logic [15:0] datagram_length,
  output logic        done,
  output logic [2:0]  packet_class,
  output logic [2:0]  track_status,
  output logic [31:0] early_gap,
  output logic        window_overflow,
  output logic [31:0] total_count,
  output logic [31:0] heartbeat_count,
  output logic [31:0] admin_count,
  output logic [31:0] unsequenced_count,
  output logic [31:0] in_order_count,
  output logic [31:0] duplicate_count,
  output logic [31:0] out_of_order_count,
  output logic [31:0] gap_total
);

  localparam int STREAMS = NUM_PORTS * 256;
  localparam int AW      = $clog2(STREAMS);
  localparam int PW      = PENDING_WINDOW;
  localparam int PWC     = $clog2(PENDING_WINDOW + 1);
  localparam int ENTRY_W = 64 + PENDING_WINDOW;

  // clamp a 33-bit offset to the window size
  function automatic logic [PWC-1:0] sat_win(input logic [32:0] x);
    logic [PWC-1:0] r;
    if (x > 33'(PW)) begin
      r = PWC'(PW);
    end else begin
      r = x[PWC-1:0];
    end
    return r;
  endfunction

  // ones below bit n
  function automatic logic [PW-1:0] low_mask(input logic [PWC-1:0] n);
    return ~({PW{1'b1}} << n);
  endfunction

  // tracker memory and its ports
  logic [ENTRY_W-1:0] mem [STREAMS];
  logic [ENTRY_W-1:0] mem_rd;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic               accept;

  // reset sweep
  logic               clearing;
  logic [AW-1:0]      clr_addr;

  // latched request
  logic               req_op;
  logic [1:0]         req_port;
  logic [31:0]        req_seq;
  logic [7:0]         req_cnt;
  logic [15:0]        req_len;
  logic [AW-1:0]      req_addr;
  logic               fwd_hit;
  logic [ENTRY_W-1:0] fwd_data;

  // pipeline valids
  logic v1;
  logic v2;

  // first stage results
  logic               s1_clear, s1_clear_next;
  logic [2:0]         s1_cls, s1_cls_next;
  logic [2:0]         s1_status, s1_status_next;
  logic [31:0]        s1_gap, s1_gap_next;
  logic               s1_ovf, s1_ovf_next;
  logic               s1_we, s1_we_next;
  logic               s1_inorder, s1_inorder_next;
  logic [AW-1:0]      s1_addr;
  logic [31:0]        s1_lc, s1_lc_next;
  logic [31:0]        s1_hs, s1_hs_next;
  logic [PW-1:0]      s1_win, s1_win_next;

  // statistics counters
  logic [31:0] stat [NUM_STATS];

  // first stage working values
  logic [ENTRY_W-1:0] entry;
  logic [31:0]        e_lc, e_hs, expected, last;
  logic [PW-1:0]      e_win, mark;
  logic [7:0]         mc;
  logic [32:0]        end33;
  logic               ignore, tracked;

  // second stage working values
  logic [PWC-1:0]     drain;
  logic [31:0]        lc_fin;
  logic [PW-1:0]      win_fin;

  assign busy    = clearing | v1;
  assign accept  = start & ~busy;
  assign rd_addr = AW'({port_index, unit_id});

  // request latch and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      done     <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      done <= v2;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(STREAMS - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= op;
      req_port <= port_index;
      req_seq  <= seq_number;
      req_cnt  <= msg_count;
      req_len  <= datagram_length;
      req_addr <= rd_addr;
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // tracker memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      mem_rd <= mem[rd_addr];
    end
  end

  // write port: sweep after reset, else second stage write-back
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = v2 & s1_we;
      wr_addr = s1_addr;
      wr_data = {lc_fin, s1_hs, win_fin};
    end
  end

  // first stage: classing, order decision, window shift or early marks
  always_comb begin
    entry    = fwd_hit ? fwd_data : mem_rd;
    e_lc     = entry[ENTRY_W-1 -: 32];
    e_hs     = entry[ENTRY_W-33 -: 32];
    e_win    = entry[PW-1:0];
    mc       = (req_cnt == 8'd0) ? 8'd1 : req_cnt;
    last     = req_seq + 32'(mc) - 32'd1;
    expected = e_lc + 32'd1;
    ignore   = req_op || (req_len < 16'(HEADER_BYTES)) || (7'(req_port) >= 7'(NUM_PORTS));
    tracked  = !ignore && (req_seq != 32'd0);

    s1_clear_next   = req_op;
    s1_status_next  = ORD_NONE;
    s1_gap_next     = 32'd0;
    s1_ovf_next     = 1'b0;
    s1_we_next      = 1'b0;
    s1_inorder_next = 1'b0;
    s1_lc_next      = e_lc;
    s1_hs_next      = e_hs;
    s1_win_next     = e_win;

    // header class
    if (ignore) begin
      s1_cls_next = CLS_IGNORED;
    end else if (req_seq != 32'd0) begin
      s1_cls_next = CLS_DATA;
    end else if (req_cnt != 8'd0) begin
      s1_cls_next = CLS_UNSEQUENCED;
    end else if (req_len <= HEARTBEAT_MAX_LEN) begin
      s1_cls_next = CLS_HEARTBEAT;
    end else begin
      s1_cls_next = CLS_ADMIN;
    end

    // early marks, wrapping offsets land in the low bits
    s1_gap_next = req_seq - expected;
    end33       = {1'b0, s1_gap_next} + 33'(mc);
    if (end33[32]) begin
      mark = low_mask(sat_win({1'b0, end33[31:0]}));
    end else begin
      mark = low_mask(sat_win(end33)) & ~low_mask(sat_win({1'b0, s1_gap_next}));
    end

    // tracker update
    if (tracked) begin
      if (e_lc == 32'd0 && e_hs == 32'd0) begin
        s1_status_next = ORD_FIRST;
        s1_we_next     = 1'b1;
        s1_lc_next     = last;
        s1_hs_next     = last;
        s1_win_next    = '0;
        s1_gap_next    = 32'd0;
      end else if (req_seq == expected) begin
        s1_status_next  = ORD_IN_ORDER;
        s1_we_next      = 1'b1;
        s1_inorder_next = 1'b1;
        s1_lc_next      = last;
        s1_win_next     = e_win >> mc;
        s1_gap_next     = 32'd0;
      end else if (req_seq < expected) begin
        s1_status_next = ORD_DUPLICATE;
        s1_gap_next    = 32'd0;
      end else begin
        s1_status_next = ORD_EARLY;
        s1_we_next     = 1'b1;
        s1_win_next    = e_win | mark;
        s1_ovf_next    = end33 > 33'(PW);
        if (last > e_hs) begin
          s1_hs_next = last;
        end
      end
    end else begin
      s1_gap_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      s1_clear   <= s1_clear_next;
      s1_cls     <= s1_cls_next;
      s1_status  <= s1_status_next;
      s1_gap     <= s1_gap_next;
      s1_ovf     <= s1_ovf_next;
      s1_we      <= s1_we_next;
      s1_inorder <= s1_inorder_next;
      s1_addr    <= req_addr;
      s1_lc      <= s1_lc_next;
      s1_hs      <= s1_hs_next;
      s1_win     <= s1_win_next;
    end
  end

  // second stage: count leading pending marks and drain them after an in-order packet
  always_comb begin
    drain = PWC'(PW);
    for (int j = PW - 1; j >= 0; j--) begin
      if (!s1_win[j]) begin
        drain = PWC'(j);
      end
    end
    if (s1_inorder) begin
      win_fin = s1_win >> drain;
      lc_fin  = s1_lc + 32'(drain);
    end else begin
      win_fin = s1_win;
      lc_fin  = s1_lc;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (v2) begin
      packet_class    <= s1_cls;
      track_status    <= s1_status;
      early_gap       <= s1_gap;
      window_overflow <= s1_ovf;
    end
  end

  // statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_STATS; k++) begin
        stat[k] <= 32'd0;
      end
    end else if (v2) begin
      if (s1_clear) begin
        for (int k = 0; k < NUM_STATS; k++) begin
          stat[k] <= 32'd0;
        end
      end else if (s1_cls != CLS_IGNORED) begin
        stat[STAT_TOTAL] <= stat[STAT_TOTAL] + 32'd1;
        case (s1_cls)
          CLS_HEARTBEAT:   stat[STAT_HEARTBEAT] <= stat[STAT_HEARTBEAT] + 32'd1;
          CLS_ADMIN:       stat[STAT_ADMIN] <= stat[STAT_ADMIN] + 32'd1;
          CLS_UNSEQUENCED: stat[STAT_UNSEQ] <= stat[STAT_UNSEQ] + 32'd1;
          default: ;
        endcase
        case (s1_status)
          ORD_FIRST, ORD_IN_ORDER: begin
            stat[STAT_IN_ORDER] <= stat[STAT_IN_ORDER] + 32'd1;
          end
          ORD_DUPLICATE: begin
            stat[STAT_DUPLICATE] <= stat[STAT_DUPLICATE] + 32'd1;
          end
          ORD_EARLY: begin
            stat[STAT_EARLY] <= stat[STAT_EARLY] + 32'd1;
            stat[STAT_GAP]   <= stat[STAT_GAP] + s1_gap;
          end
          default: ;
        endcase
      end
    end
  end

  assign total_count        = stat[STAT_TOTAL];
  assign heartbeat_count    = stat[STAT_HEARTBEAT];
  assign admin_count        = stat[STAT_ADMIN];
  assign unsequenced_count  = stat[STAT_UNSEQ];
  assign in_order_count     = stat[STAT_IN_ORDER];
  assign duplicate_count    = stat[STAT_DUPLICATE];
  assign out_of_order_count = stat[STAT_EARLY];
  assign gap_total          = stat[STAT_GAP];

  // checks
  `FSGT_ASSERT_NEVER(a_one_phase, $countones({clearing, v1, v2}) > 1, "overlapping phases")
  `FSGT_ASSERT_NEVER(a_done_in_sweep, clearing && done, "result during memory sweep")
  `FSGT_ASSERT_IMPLIES(a_status_data, done && track_status != ORD_NONE,
                       packet_class == CLS_DATA, "tracked status on a non-data packet")
  `FSGT_ASSERT_IMPLIES(a_ovf_early, done && window_overflow,
                       track_status == ORD_EARLY, "overflow without early packet")
  `FSGT_ASSERT_IMPLIES(a_gap_early, done && early_gap != 32'd0,
                       track_status == ORD_EARLY, "gap without early packet")

endmodule

### tb/sv/gap_tracker_checker.sv
// checker for the feed sequence gap tracker: watches requests and results, predicts, compares
`timescale 1ns / 100ps

module gap_tracker_checker
  import fsgt_pkg::*;
#(
  parameter int NUM_PORTS      = NUM_PORTS_DEF,
  parameter int PENDING_WINDOW = PENDING_WINDOW_DEF,
  parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [1:0]  port_index,
  input  logic [7:0]  unit_id,
  input  logic [31:0] seq_number,
  input  logic [7:0]  msg_count,
  input  logic [15:0] datagram_length,
  input  logic        done,
  input  logic [2:0]  packet_class,
  input  logic [2:0]  track_status,
  input  logic [31:0] early_gap,
  input  logic        window_overflow,
  input  logic [31:0] total_count,
  input  logic [31:0] heartbeat_count,
  input  logic [31:0] admin_count,
  input  logic [31:0] unsequenced_count,
  input  logic [31:0] in_order_count,
  input  logic [31:0] duplicate_count,
  input  logic [31:0] out_of_order_count,
  input  logic [31:0] gap_total,
  output int          fail_count,
  output int          outstanding
);

  localparam int NUM_STREAMS = NUM_PORTS * 256;
  localparam int REPORT_MAX  = 200;

  typedef struct packed {
    logic [2:0]                  cls;
    logic [2:0]                  status;
    logic [31:0]                 gap;
    logic                        ovf;
    logic [NUM_STATS-1:0][31:0]  stats;
  } header_result_t;

  // per-stream tracker copy and statistics
  logic [31:0]               confirmed_seq [NUM_STREAMS];
  logic [31:0]               highest_seq   [NUM_STREAMS];
  logic [PENDING_WINDOW-1:0] early_marks   [NUM_STREAMS];
  logic [31:0]               stat_regs     [NUM_STATS];

  header_result_t expected_results [$];
  int             fails = 0;

  // classify one request and update the stream tracker, returning the expected result
  function automatic header_result_t track_header(
    input logic        op_i,
    input logic [1:0]  port_i,
    input logic [7:0]  unit_i,
    input logic [31:0] seq_i,
    input logic [7:0]  cnt_i,
    input logic [15:0] len_i
  );
    header_result_t            r;
    int                        key;
    logic [31:0]               span;
    logic [31:0]               last;
    logic [31:0]               next_needed;
    logic [31:0]               offset;
    logic [PENDING_WINDOW-1:0] w;
    r        = '0;
    r.cls    = CLS_IGNORED;
    r.status = ORD_NONE;
    if (op_i) begin
      for (int k = 0; k < NUM_STATS; k++) stat_regs[k] = '0;
    end else if (len_i < HEADER_BYTES || port_i >= NUM_PORTS) begin
      // short datagram or unknown port: nothing counted
    end else begin
      // header class
      if (seq_i == 32'd0) begin
        if (cnt_i == 8'd0 && len_i <= HEARTBEAT_MAX_LEN) begin
          r.cls = CLS_HEARTBEAT;
          stat_regs[STAT_HEARTBEAT]++;
        end else if (cnt_i == 8'd0) begin
          r.cls = CLS_ADMIN;
          stat_regs[STAT_ADMIN]++;
        end else begin
          r.cls = CLS_UNSEQUENCED;
          stat_regs[STAT_UNSEQ]++;
        end
      end else begin
        r.cls = CLS_DATA;
      end
      stat_regs[STAT_TOTAL]++;

      // sequenced packets go through the stream tracker
      if (seq_i != 32'd0) begin
        key  = int'(port_i) * 256 + int'(unit_i);
        span = (cnt_i == 8'd0) ? 32'd1 : 32'(cnt_i);
        last = seq_i + span - 32'd1;
        w    = early_marks[key];
        if (confirmed_seq[key] == 32'd0 && highest_seq[key] == 32'd0) begin
          confirmed_seq[key] = last;
          highest_seq[key]   = last;
          w                  = '0;
          r.status           = ORD_FIRST;
          stat_regs[STAT_IN_ORDER]++;
        end else begin
          next_needed = confirmed_seq[key] + 32'd1;
          if (seq_i == next_needed) begin
            // slide the window past this packet, then drain marks that now lead
            confirmed_seq[key] = last;
            w = w >> span;
            while (w[0]) begin
              w = w >> 1;
              confirmed_seq[key]++;
            end
            r.status = ORD_IN_ORDER;
            stat_regs[STAT_IN_ORDER]++;
          end else if (seq_i < next_needed) begin
            r.status = ORD_DUPLICATE;
            stat_regs[STAT_DUPLICATE]++;
          end else begin
            // early: mark each message, offsets wrap at 32 bits
            r.gap = seq_i - next_needed;
            for (int i = 0; i < span; i++) begin
              offset = r.gap + 32'(i);
              if (offset < PENDING_WINDOW) w[offset] = 1'b1;
              else r.ovf = 1'b1;
            end
            if (last > highest_seq[key]) highest_seq[key] = last;
            r.status = ORD_EARLY;
            stat_regs[STAT_EARLY]++;
            stat_regs[STAT_GAP] += r.gap;
          end
        end
        early_marks[key] = w;
      end
    end
    for (int k = 0; k < NUM_STATS; k++) r.stats[k] = stat_regs[k];
    return r;
  endfunction

  // one field against its expectation
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("%0t: %s expected %0d (0x%08h) actual %0d (0x%08h)",
                 $time, name, want, want, got, got);
    end
  endtask

  // sample the request and result channels
  always @(posedge clk) begin
    header_result_t             want;
    logic [NUM_STATS-1:0][31:0] got_stats;
    if (rst) begin
      for (int k = 0; k < NUM_STREAMS; k++) begin
        confirmed_seq[k] = '0;
        highest_seq[k]   = '0;
        early_marks[k]   = '0;
      end
      for (int k = 0; k < NUM_STATS; k++) stat_regs[k] = '0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: result expected none actual class %0d status %0d",
                     $time, packet_class, track_status);
        end else begin
          want = expected_results.pop_front();
          got_stats[STAT_TOTAL]     = total_count;
          got_stats[STAT_HEARTBEAT] = heartbeat_count;
          got_stats[STAT_ADMIN]     = admin_count;
          got_stats[STAT_UNSEQ]     = unsequenced_count;
          got_stats[STAT_IN_ORDER]  = in_order_count;
          got_stats[STAT_DUPLICATE] = duplicate_count;
          got_stats[STAT_EARLY]     = out_of_order_count;
          got_stats[STAT_GAP]       = gap_total;
          check_field("packet_class", 32'(want.cls), 32'(packet_class));
          check_field("track_status", 32'(want.status), 32'(track_status));
          check_field("early_gap", want.gap, early_gap);
          check_field("window_overflow", 32'(want.ovf), 32'(window_overflow));
          check_field("total_count", want.stats[STAT_TOTAL], got_stats[STAT_TOTAL]);
          check_field("heartbeat_count", want.stats[STAT_HEARTBEAT],
                      got_stats[STAT_HEARTBEAT]);
          check_field("admin_count", want.stats[STAT_ADMIN], got_stats[STAT_ADMIN]);
          check_field("unsequenced_count", want.stats[STAT_UNSEQ], got_stats[STAT_UNSEQ]);
          check_field("in_order_count", want.stats[STAT_IN_ORDER],
                      got_stats[STAT_IN_ORDER]);
          check_field("duplicate_count", want.stats[STAT_DUPLICATE],
                      got_stats[STAT_DUPLICATE]);
          check_field("out_of_order_count", want.stats[STAT_EARLY], got_stats[STAT_EARLY]);
          check_field("gap_total", want.stats[STAT_GAP], got_stats[STAT_GAP]);
        end
      end
      if (start && !busy)
        expected_results.insert(expected_results.size(),
                                track_header(op, port_index, unit_id, seq_number,
                                             msg_count, datagram_length));
    end
    fail_count  <= fails;
    outstanding <= expected_results.size();
  end

endmodule

### tb/sv/tb_top.sv
// testbench top for the feed sequence gap tracker: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module tb_top
  import fsgt_pkg::*;
();

  localparam int RANDOM_ITEMS   = 1100;
  localparam int HOT_STREAMS    = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        start           = 1'b0;
  logic        op              = 1'b0;
  logic [1:0]  port_index      = '0;
  logic [7:0]  unit_id         = '0;
  logic [31:0] seq_number      = '0;
  logic [7:0]  msg_count       = '0;
  logic [15:0] datagram_length = '0;

  logic        busy;
  logic        done;
  logic [2:0]  packet_class;
  logic [2:0]  track_status;
  logic [31:0] early_gap;
  logic        window_overflow;
  logic [31:0] total_count;
  logic [31:0] heartbeat_count;
  logic [31:0] admin_count;
  logic [31:0] unsequenced_count;
  logic [31:0] in_order_count;
  logic [31:0] duplicate_count;
  logic [31:0] out_of_order_count;
  logic [31:0] gap_total;

  int fail_count;
  int outstanding;
  int idle_pct     = 0;
  int quiet_cycles = 0;

  // well-formed streams: next sequence and one open hole per stream
  logic [31:0] next_seq   [HOT_STREAMS];
  logic [7:0]  hole_len   [HOT_STREAMS];
  logic [7:0]  hole_span  [HOT_STREAMS];
  logic        stream_up  [HOT_STREAMS];

  always #2 clk = ~clk;

  feed_sequence_gap_tracker_unit dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .op                 (op),
    .port_index         (port_index),
    .unit_id            (unit_id),
    .seq_number         (seq_number),
    .msg_count          (msg_count),
    .datagram_length    (datagram_length),
    .done               (done),
    .packet_class       (packet_class),
    .track_status       (track_status),
    .early_gap          (early_gap),
    .window_overflow    (window_overflow),
    .total_count        (total_count),
    .heartbeat_count    (heartbeat_count),
    .admin_count        (admin_count),
    .unsequenced_count  (unsequenced_count),
    .in_order_count     (in_order_count),
    .duplicate_count    (duplicate_count),
    .out_of_order_count (out_of_order_count),
    .gap_total          (gap_total)
  );

  gap_tracker_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .op                 (op),
    .port_index         (port_index),
    .unit_id            (unit_id),
    .seq_number         (seq_number),
    .msg_count          (msg_count),
    .datagram_length    (datagram_length),
    .done               (done),
    .packet_class       (packet_class),
    .track_status       (track_status),
    .early_gap          (early_gap),
    .window_overflow    (window_overflow),
    .total_count        (total_count),
    .heartbeat_count    (heartbeat_count),
    .admin_count        (admin_count),
    .unsequenced_count  (unsequenced_count),
    .in_order_count     (in_order_count),
    .duplicate_count    (duplicate_count),
    .out_of_order_count (out_of_order_count),
    .gap_total          (gap_total),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  // drive one request, hold it until taken, then maybe leave the line idle
  task automatic send_request(
    input logic        op_i,
    input logic [1:0]  port_i,
    input logic [7:0]  unit_i,
    input logic [31:0] seq_i,
    input logic [7:0]  cnt_i,
    input logic [15:0] len_i
  );
    op              <= op_i;
    port_index      <= port_i;
    unit_id         <= unit_i;
    seq_number      <= seq_i;
    msg_count       <= cnt_i;
    datagram_length <= len_i;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // watchdog: too long with neither a request taken nor a result shown
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int          s;
    int          g;
    int          m;
    int          span;
    int          phase_pct [4];
    logic [31:0] seq;
    logic [7:0]  cnt;
    logic [15:0] len;
    logic [7:0]  unit;

    phase_pct[0] = 0;
    phase_pct[1] = 46;
    phase_pct[2] = 0;
    phase_pct[3] = 33;
    for (int k = 0; k < HOT_STREAMS; k++) begin
      next_seq[k]  = $urandom_range(32'h7000_0000, 1000);
      hole_len[k]  = '0;
      hole_span[k] = '0;
      stream_up[k] = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: classes and their length limits
    send_request(1'b0, 2'd0, 8'd200, 32'd0, 8'd0, 16'd8);
    send_request(1'b0, 2'd1, 8'd201, 32'd0, 8'd0, 16'd20);
    send_request(1'b0, 2'd2, 8'd202, 32'd0, 8'd0, 16'd21);
    send_request(1'b0, 2'd3, 8'd255, 32'd0, 8'd0, 16'd65535);
    send_request(1'b0, 2'd1, 8'd203, 32'd0, 8'd255, 16'd100);
    // short datagrams are ignored
    send_request(1'b0, 2'd3, 8'd255, 32'd5, 8'd0, 16'd7);
    send_request(1'b0, 2'd0, 8'd200, 32'hFFFF_FFFF, 8'd255, 16'd0);
    // first at the top of the sequence space, then early gaps that wrap
    send_request(1'b0, 2'd3, 8'd255, 32'hFFFF_FFFF, 8'd0, 16'd64);
    send_request(1'b0, 2'd3, 8'd255, 32'hFFFF_FFFF, 8'd0, 16'd64);
    send_request(1'b0, 2'd3, 8'd255, 32'hFFFF_FFFE, 8'd3, 16'd64);
    // first, early within and across the window edge, in order with drain
    send_request(1'b0, 2'd0, 8'd200, 32'd1000, 8'd4, 16'd64);
    send_request(1'b0, 2'd0, 8'd200, 32'd1010, 8'd3, 16'd64);
    send_request(1'b0, 2'd0, 8'd200, 32'd1067, 8'd2, 16'd64);
    send_request(1'b0, 2'd0, 8'd200, 32'd1004, 8'd6, 16'd64);
    // duplicates
    send_request(1'b0, 2'd0, 8'd200, 32'd1012, 8'd1, 16'd64);
    send_request(1'b0, 2'd0, 8'd200, 32'd1, 8'd0, 16'd64);
    // in order shift past the whole window drops leftover marks
    send_request(1'b0, 2'd0, 8'd200, 32'd1013, 8'd255, 16'd64);
    send_request(1'b0, 2'd0, 8'd200, 32'h8000_0000, 8'd200, 16'd1500);
    // clear with every field at its top, then tracking carries on
    send_request(1'b1, 2'd3, 8'd255, 32'hFFFF_FFFF, 8'd255, 16'd65535);
    send_request(1'b0, 2'd1, 8'd204, 32'hFFFF_FFF0, 8'd32, 16'd64);
    send_request(1'b0, 2'd1, 8'd204, 32'h0000_0010, 8'd0, 16'd64);
    send_request(1'b0, 2'd2, 8'd205, 32'd0, 8'd0, 16'd19);
    send_request(1'b1, 2'd0, 8'd0, 32'd0, 8'd0, 16'd0);
    send_request(1'b0, 2'd0, 8'd200, 32'd1268, 8'd0, 16'd9);

    // random part in idling phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = phase_pct[(n * 4) / RANDOM_ITEMS];
      m = $urandom_range(99);
      if (m < 2) begin
        // statistics clear
        send_request(1'b1, 2'($urandom_range(3)), 8'($urandom_range(255)), $urandom(),
                     8'($urandom_range(255)), 16'($urandom_range(65535)));
      end else if (m < 62) begin
        // well-formed stream traffic
        s   = $urandom_range(HOT_STREAMS - 1);
        g   = $urandom_range(99);
        len = 16'($urandom_range(65535, HEADER_BYTES_DEF));
        if (!stream_up[s] || g < 55) begin
          if (hole_len[s] != 0) begin
            // fill the hole, the early marks drain behind it
            seq = next_seq[s];
            cnt = hole_len[s];
            next_seq[s] += 32'(hole_span[s]);
            hole_len[s] = '0;
          end else begin
            seq  = next_seq[s];
            cnt  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
            span = (cnt == 0) ? 1 : int'(cnt);
            next_seq[s] += 32'(span);
          end
          stream_up[s] = 1'b1;
        end else if (g < 80 && hole_len[s] == 0) begin
          // early packet opens a hole ahead of the next sequence
          g    = $urandom_range(12, 1);
          cnt  = 8'($urandom_range(4));
          span = (cnt == 0) ? 1 : int'(cnt);
          seq  = next_seq[s] + 32'(g);
          hole_len[s]  = 8'(g);
          hole_span[s] = 8'(g + span);
        end else if (g < 80 && hole_len[s] > 1) begin
          // single message landing inside the open hole
          seq = next_seq[s] + 32'($urandom_range(int'(hole_len[s]) - 1, 1));
          cnt = 8'd0;
        end else begin
          seq = next_seq[s] - 32'd1 - 32'($urandom_range(20));
          cnt = 8'($urandom_range(255));
        end
        send_request(1'b0, 2'(s), 8'(s), seq, cnt, len);
      end else begin
        // noise: any class, any length, streams away from the well-formed ones
        seq  = ($urandom_range(99) < 30) ? 32'd0 : $urandom();
        cnt  = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
        len  = ($urandom_range(1) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(65535));
        unit = (seq == 32'd0) ? 8'($urandom_range(255)) : 8'($urandom_range(255, HOT_STREAMS));
        send_request(1'b0, 2'($urandom_range(3)), unit, seq, cnt, len);
      end
    end
    start <= 1'b0;

    // drain and verdict
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/fsgt_pkg.sv
rtl/feed_sequence_gap_tracker_unit.sv
tb/sv/gap_tracker_checker.sv
tb/sv/tb_top.sv
